@@ src/line_sphere_intersect_unit_macros.svh @@
// Assertion macros for the line-sphere intersection unit
`ifndef LINE_SPHERE_INTERSECT_UNIT_MACROS_SVH
`define LINE_SPHERE_INTERSECT_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked on clk, off during rst
`define LSI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("line sphere unit: same-cycle check failed");
// next-cycle implication
`define LSI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("line sphere unit: next-cycle check failed");
`else
`define LSI_ASSERT_IMP(lbl, ante, cons)
`define LSI_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ src/lsi_pkg.sv @@
// Widths, codes and types shared by the line-sphere intersection files
package lsi_pkg;

  localparam int FRAC_BITS = 16;

  localparam int CRD_W  = 32;              // coordinate / direction
  localparam int RAD_W  = 31;              // radius
  localparam int OFS_W  = CRD_W + 1;       // center minus source
  localparam int OD_W   = OFS_W + CRD_W;   // one term of O.D
  localparam int A_W    = 2 * CRD_W;       // D.D, unsigned
  localparam int B_W    = OD_W + 1;        // O.D, signed
  localparam int OO_W   = 2 * OFS_W;       // O.O, unsigned
  localparam int RR_W   = 2 * RAD_W;       // r^2
  localparam int C_W    = OO_W + 1;        // O.O - r^2, signed
  localparam int LIMB_W = 33;
  localparam int MAG_W  = 2 * LIMB_W;      // magnitudes split in two limbs
  localparam int PP_W   = 2 * LIMB_W;      // one partial product
  localparam int ACC_W  = 2 * MAG_W;
  localparam int PROD_W = 130;             // b^2 and a*|c|
  localparam int DISC_W = PROD_W + 1;
  localparam int Y_W    = PROD_W + 2 * FRAC_BITS;  // radicand, even
  localparam int R_W    = Y_W / 2;                 // root bits
  localparam int REM_W  = R_W + 2;
  localparam int X_W    = B_W + FRAC_BITS;
  localparam int N_W    = X_W + 2;         // numerators
  localparam int M_W    = N_W - 1;         // numerator magnitude
  localparam int T_W    = 32;
  localparam int Q_BITS = T_W - 1;         // quotient bits below saturation
  localparam int CMP_W  = A_W + Q_BITS;

  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = CFG_IDX_W'(3);

  localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(1) << FRAC_BITS;
  localparam logic [T_W-1:0] T_MIN = {1'b1, {(T_W-1){1'b0}}};
  localparam logic [T_W-1:0] T_MAX = {1'b0, {(T_W-1){1'b1}}};

  typedef enum logic [1:0] {KIND_MISS, KIND_UNB, KIND_HIT} kind_t;

endpackage

@@ src/lsi_if.sv @@
// Request and result channel interfaces of the line-sphere intersection unit
interface lsi_ray_if;
  import lsi_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [CRD_W-1:0] source_x;
  logic signed [CRD_W-1:0] source_y;
  logic signed [CRD_W-1:0] source_z;
  logic signed [CRD_W-1:0] dir_x;
  logic signed [CRD_W-1:0] dir_y;
  logic signed [CRD_W-1:0] dir_z;
  modport source (output valid, source_x, source_y, source_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink   (input valid, source_x, source_y, source_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface

interface lsi_res_if;
  import lsi_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic                  unbounded;
  logic signed [T_W-1:0] t_near;
  logic signed [T_W-1:0] t_far;
  modport source (output valid, hit, unbounded, t_near, t_far, input ready);
  modport sink   (input valid, hit, unbounded, t_near, t_far, output ready);
endinterface

@@ src/line_sphere_intersect_unit.sv @@
// Line-sphere intersection, fully pipelined: one request per cycle; request to
// result at Q16.16 through 7 setup stages, one stage per root bit (81), 3 more,
// one stage per quotient bit (31) and 1 output register; the bit-serial square root
// sets the depth. Any stall on the result side freezes every stage at once.
// Synchronous reset clears all valid bits, the center to 0, the radius to 1.0.
`include "line_sphere_intersect_unit_macros.svh"
module line_sphere_intersect_unit (
  input  logic                           clk,
  input  logic                           rst,
  lsi_ray_if.sink                        ray,
  lsi_res_if.source                      res,
  input  logic                           cfg_we,
  input  logic [lsi_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [lsi_pkg::CFG_W-1:0]      cfg_data
);
  import lsi_pkg::*;

  // global advance: every stage moves when the output slot is free or taken
  logic adv;
  logic res_vld;
  assign adv = !res_vld || res.ready;
  assign ray.ready = adv;

  // ---------------------------------------------------------------- config
  logic signed [CRD_W-1:0] center [3];
  logic [RAD_W-1:0]        radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      center[0] <= '0;
      center[1] <= '0;
      center[2] <= '0;
      radius    <= RADIUS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_CENTER_X: center[0] <= $signed(cfg_data[CRD_W-1:0]);
        REG_CENTER_Y: center[1] <= $signed(cfg_data[CRD_W-1:0]);
        REG_CENTER_Z: center[2] <= $signed(cfg_data[CRD_W-1:0]);
        REG_RADIUS:   radius    <= cfg_data[RAD_W-1:0];
      endcase
    end
  end

  logic signed [CRD_W-1:0] src [3];
  logic signed [CRD_W-1:0] dir [3];
  always_comb begin
    src[0] = ray.source_x;
    src[1] = ray.source_y;
    src[2] = ray.source_z;
    dir[0] = ray.dir_x;
    dir[1] = ray.dir_y;
    dir[2] = ray.dir_z;
  end

  // ---------------------------------------------- stage 1: O = C - S
  logic                    s1_vld;
  logic signed [OFS_W-1:0] s1_o [3];
  logic signed [CRD_W-1:0] s1_d [3];
  logic [RAD_W-1:0]        s1_r;

  always_ff @(posedge clk) begin
    if (rst) s1_vld <= 1'b0;
    else if (adv) s1_vld <= ray.valid;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s1_o[i] <= OFS_W'(center[i]) - OFS_W'(src[i]);
        s1_d[i] <= dir[i];
      end
      s1_r <= radius;
    end
  end

  // ---------------------------------- stage 2: per-axis products, r^2
  logic                   s2_vld;
  logic [A_W-1:0]         s2_dd [3];
  logic signed [OD_W-1:0] s2_od [3];
  logic [OO_W-1:0]        s2_oo [3];
  logic [RR_W-1:0]        s2_rr;

  always_ff @(posedge clk) begin
    if (rst) s2_vld <= 1'b0;
    else if (adv) s2_vld <= s1_vld;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s2_dd[i] <= A_W'(s1_d[i] * s1_d[i]);
        s2_od[i] <= OD_W'(s1_o[i] * s1_d[i]);
        s2_oo[i] <= OO_W'(s1_o[i] * s1_o[i]);
      end
      s2_rr <= RR_W'(s1_r * s1_r);
    end
  end

  // ------------------- stage 3: a = D.D, b = O.D, c = O.O - r^2
  logic                  s3_vld;
  logic [A_W-1:0]        s3_a;
  logic signed [B_W-1:0] s3_b;
  logic signed [C_W-1:0] s3_c;

  always_ff @(posedge clk) begin
    if (rst) s3_vld <= 1'b0;
    else if (adv) s3_vld <= s2_vld;
    if (adv) begin
      s3_a <= s2_dd[0] + s2_dd[1] + s2_dd[2];
      s3_b <= B_W'(s2_od[0]) + B_W'(s2_od[1]) + B_W'(s2_od[2]);
      s3_c <= $signed(C_W'(s2_oo[0]) + C_W'(s2_oo[1]) + C_W'(s2_oo[2]) - C_W'(s2_rr));
    end
  end

  // ---------------------------------------- stage 4: magnitudes, flags
  logic                  s4_vld;
  logic [A_W-1:0]        s4_a;
  logic signed [B_W-1:0] s4_b;
  logic [MAG_W-1:0]      s4_bm;
  logic [MAG_W-1:0]      s4_cm;
  logic                  s4_cneg;
  logic                  s4_azero;

  always_ff @(posedge clk) begin
    if (rst) s4_vld <= 1'b0;
    else if (adv) s4_vld <= s3_vld;
    if (adv) begin
      s4_a     <= s3_a;
      s4_b     <= s3_b;
      s4_bm    <= s3_b[B_W-1] ? MAG_W'(-s3_b) : MAG_W'(s3_b);
      s4_cm    <= s3_c[C_W-1] ? MAG_W'(-s3_c) : MAG_W'(s3_c);
      s4_cneg  <= s3_c[C_W-1];
      s4_azero <= (s3_a == '0);
    end
  end

  // ------------------ stage 5: limb partial products of b^2 and a*|c| (a's upper limb is 31 bits)
  logic [LIMB_W-1:0]     bl, bh, al, cl, ch;
  logic [A_W-LIMB_W-1:0] ah;
  assign bl = s4_bm[LIMB_W-1:0];
  assign bh = s4_bm[MAG_W-1:LIMB_W];
  assign cl = s4_cm[LIMB_W-1:0];
  assign ch = s4_cm[MAG_W-1:LIMB_W];
  assign al = s4_a[LIMB_W-1:0];
  assign ah = s4_a[A_W-1:LIMB_W];

  logic                  s5_vld;
  logic [PP_W-1:0]       s5_bll, s5_blh, s5_bhh;
  logic [PP_W-1:0]       s5_all, s5_alh, s5_ahl, s5_ahh;
  logic [A_W-1:0]        s5_a;
  logic signed [B_W-1:0] s5_b;
  logic                  s5_cneg, s5_azero;

  always_ff @(posedge clk) begin
    if (rst) s5_vld <= 1'b0;
    else if (adv) s5_vld <= s4_vld;
    if (adv) begin
      s5_bll   <= PP_W'(bl * bl);
      s5_blh   <= PP_W'(bl * bh);
      s5_bhh   <= PP_W'(bh * bh);
      s5_all   <= PP_W'(al * cl);
      s5_alh   <= PP_W'(al * ch);
      s5_ahl   <= PP_W'(ah * cl);
      s5_ahh   <= PP_W'(ah * ch);
      s5_a     <= s4_a;
      s5_b     <= s4_b;
      s5_cneg  <= s4_cneg;
      s5_azero <= s4_azero;
    end
  end

  // ----------------------------------- stage 6: sum the partial products
  logic                  s6_vld;
  logic [PROD_W-1:0]     s6_bb, s6_ac;
  logic [A_W-1:0]        s6_a;
  logic signed [B_W-1:0] s6_b;
  logic                  s6_cneg, s6_azero;

  always_ff @(posedge clk) begin
    if (rst) s6_vld <= 1'b0;
    else if (adv) s6_vld <= s5_vld;
    if (adv) begin
      // cross term of a square appears twice: one extra shift
      s6_bb <= PROD_W'(ACC_W'(s5_bll) + (ACC_W'(s5_blh) << (LIMB_W + 1))
                       + (ACC_W'(s5_bhh) << (2 * LIMB_W)));
      s6_ac <= PROD_W'(ACC_W'(s5_all) + ((ACC_W'(s5_alh) + ACC_W'(s5_ahl)) << LIMB_W)
                       + (ACC_W'(s5_ahh) << (2 * LIMB_W)));
      s6_a     <= s5_a;
      s6_b     <= s5_b;
      s6_cneg  <= s5_cneg;
      s6_azero <= s5_azero;
    end
  end

  // ------------- stage 7 (root stage 0): discriminant, case, radicand
  // The root runs one bit per stage; element k holds the state after k bits.
  logic                  sq_vld  [R_W+1];
  logic [Y_W-1:0]        sq_y    [R_W+1];
  logic [REM_W-1:0]      sq_rem  [R_W+1];
  logic [R_W-1:0]        sq_root [R_W+1];
  logic signed [X_W-1:0] sq_x    [R_W+1];
  logic [A_W-1:0]        sq_a    [R_W+1];
  kind_t                 sq_kind [R_W+1];

  logic signed [DISC_W-1:0] disc;
  kind_t                    kind7;
  always_comb begin
    // b^2 - a*c with c = +/-|c|
    disc = s6_cneg ? $signed(DISC_W'(s6_bb) + DISC_W'(s6_ac))
                   : $signed(DISC_W'(s6_bb) - DISC_W'(s6_ac));
    priority if (s6_azero) kind7 = s6_cneg ? KIND_UNB : KIND_MISS;
    else if (disc[DISC_W-1]) kind7 = KIND_MISS;
    else kind7 = KIND_HIT;
  end

  always_ff @(posedge clk) begin
    if (rst) sq_vld[0] <= 1'b0;
    else if (adv) sq_vld[0] <= s6_vld;
    if (adv) begin
      // radicand disc * 2^(2F); clamp to zero when there is no real root
      sq_y[0]    <= disc[DISC_W-1] ? '0 : {disc[PROD_W-1:0], {(2*FRAC_BITS){1'b0}}};
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_x[0]    <= {s6_b, {FRAC_BITS{1'b0}}};
      sq_a[0]    <= s6_a;
      sq_kind[0] <= kind7;
    end
  end

  // ------------------------------- restoring square root, bit per stage
  for (genvar k = 0; k < R_W; k++) begin : g_sqrt
    logic [REM_W+1:0] cand, trial;
    logic             take;
    always_comb begin
      cand  = {sq_rem[k], sq_y[k][Y_W-1-2*k -: 2]};
      trial = (REM_W+2)'({sq_root[k], 2'b01});
      take  = (cand >= trial);
    end
    always_ff @(posedge clk) begin
      if (rst) sq_vld[k+1] <= 1'b0;
      else if (adv) sq_vld[k+1] <= sq_vld[k];
      if (adv) begin
        sq_rem[k+1]  <= take ? REM_W'(cand - trial) : REM_W'(cand);
        sq_root[k+1] <= {sq_root[k][R_W-2:0], take};
        sq_y[k+1]    <= sq_y[k];
        sq_x[k+1]    <= sq_x[k];
        sq_a[k+1]    <= sq_a[k];
        sq_kind[k+1] <= sq_kind[k];
      end
    end
  end

  // ---------------------- N1: numerators x - ceil(sqrt), x + floor(sqrt)
  logic                  n1_vld;
  logic signed [N_W-1:0] n1_n [2];
  logic [A_W-1:0]        n1_a;
  kind_t                 n1_kind;
  logic                  root_inexact;
  assign root_inexact = |sq_rem[R_W];

  always_ff @(posedge clk) begin
    if (rst) n1_vld <= 1'b0;
    else if (adv) n1_vld <= sq_vld[R_W];
    if (adv) begin
      n1_n[0] <= $signed(N_W'(sq_x[R_W]) - N_W'({1'b0, sq_root[R_W]})
                         - N_W'({1'b0, root_inexact}));
      n1_n[1] <= $signed(N_W'(sq_x[R_W]) + N_W'({1'b0, sq_root[R_W]}));
      n1_a    <= sq_a[R_W];
      n1_kind <= sq_kind[R_W];
    end
  end

  // ------------------------------------- N2: sign and magnitude
  logic             n2_vld;
  logic [M_W-1:0]   n2_m [2];
  logic             n2_neg [2];
  logic [A_W-1:0]   n2_a;
  kind_t            n2_kind;

  always_ff @(posedge clk) begin
    if (rst) n2_vld <= 1'b0;
    else if (adv) n2_vld <= n1_vld;
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        n2_neg[l] <= n1_n[l][N_W-1];
        n2_m[l]   <= n1_n[l][N_W-1] ? M_W'(-n1_n[l]) : M_W'(n1_n[l]);
      end
      n2_a    <= n1_a;
      n2_kind <= n1_kind;
    end
  end

  // ---------- divide stage 0: saturation test |n| >= a * 2^31, seed rem
  // Both signs saturate at that bound: the negative side lands on -2^31.
  logic              dv_vld  [Q_BITS+1];
  logic [A_W-1:0]    dv_a    [Q_BITS+1];
  kind_t             dv_kind [Q_BITS+1];
  logic [A_W-1:0]    dv_rem  [2][Q_BITS+1];
  logic [Q_BITS-1:0] dv_m    [2][Q_BITS+1];
  logic [Q_BITS-1:0] dv_q    [2][Q_BITS+1];
  logic              dv_neg  [2][Q_BITS+1];
  logic              dv_sat  [2][Q_BITS+1];

  always_ff @(posedge clk) begin
    if (rst) dv_vld[0] <= 1'b0;
    else if (adv) dv_vld[0] <= n2_vld;
    if (adv) begin
      dv_a[0]    <= n2_a;
      dv_kind[0] <= n2_kind;
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_seed
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_sat[l][0] <= (CMP_W'(n2_m[l]) >= {n2_a, {Q_BITS{1'b0}}});
        dv_rem[l][0] <= A_W'(n2_m[l] >> Q_BITS);
        dv_m[l][0]   <= n2_m[l][Q_BITS-1:0];
        dv_q[l][0]   <= '0;
        dv_neg[l][0] <= n2_neg[l];
      end
    end
  end

  // ------------------------- restoring division, quotient bit per stage
  for (genvar i = 0; i < Q_BITS; i++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) dv_vld[i+1] <= 1'b0;
      else if (adv) dv_vld[i+1] <= dv_vld[i];
      if (adv) begin
        dv_a[i+1]    <= dv_a[i];
        dv_kind[i+1] <= dv_kind[i];
      end
    end
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [A_W:0] cand;
      logic         take;
      always_comb begin
        cand = {dv_rem[l][i], dv_m[l][i][Q_BITS-1-i]};
        take = (cand >= {1'b0, dv_a[i]});
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          dv_rem[l][i+1] <= take ? A_W'(cand - {1'b0, dv_a[i]}) : A_W'(cand);
          dv_q[l][i+1]   <= {dv_q[l][i][Q_BITS-2:0], take};
          dv_m[l][i+1]   <= dv_m[l][i];
          dv_neg[l][i+1] <= dv_neg[l][i];
          dv_sat[l][i+1] <= dv_sat[l][i];
        end
      end
    end
  end

  // ------------------------- output: floor rounding, saturation, cases
  logic [T_W-1:0] tq [2];
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (dv_sat[l][Q_BITS]) tq[l] = dv_neg[l][Q_BITS] ? T_MIN : T_MAX;
      else if (dv_neg[l][Q_BITS])
        // floor of a negative ratio: -(q + 1) when a remainder is left
        tq[l] = T_W'(0) - T_W'(dv_q[l][Q_BITS]) - T_W'(|dv_rem[l][Q_BITS]);
      else tq[l] = T_W'(dv_q[l][Q_BITS]);
    end
  end

  logic                  res_hit, res_unb;
  logic signed [T_W-1:0] res_tn, res_tf;

  always_ff @(posedge clk) begin
    if (rst) res_vld <= 1'b0;
    else if (adv) res_vld <= dv_vld[Q_BITS];
    if (adv) begin
      unique case (dv_kind[Q_BITS])
        KIND_HIT: begin
          res_hit <= 1'b1;
          res_unb <= 1'b0;
          res_tn  <= $signed(tq[0]);
          res_tf  <= $signed(tq[1]);
        end
        KIND_UNB: begin
          res_hit <= 1'b1;
          res_unb <= 1'b1;
          res_tn  <= $signed(T_MIN);
          res_tf  <= $signed(T_MAX);
        end
        KIND_MISS: begin
          res_hit <= 1'b0;
          res_unb <= 1'b0;
          res_tn  <= '0;
          res_tf  <= '0;
        end
        default: begin
          res_hit <= 1'b0;
          res_unb <= 1'b0;
          res_tn  <= '0;
          res_tf  <= '0;
        end
      endcase
    end
  end

  assign res.valid     = res_vld;
  assign res.hit       = res_hit;
  assign res.unbounded = res_unb;
  assign res.t_near    = res_tn;
  assign res.t_far     = res_tf;

  // ------------------------------------------------------------- checks
  `LSI_ASSERT_NXT(a_stall_freezes, !adv, $stable(sq_vld[R_W]) && $stable(dv_vld[Q_BITS]) && $stable(res_vld))
  `LSI_ASSERT_IMP(a_near_le_far, res.valid && res.hit && !res.unbounded, res.t_near <= res.t_far)
  `LSI_ASSERT_IMP(a_miss_zero, res.valid && !res.hit, !res.unbounded && res.t_near == '0 && res.t_far == '0)

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the line-sphere intersection unit
`timescale 1ns / 1ps

module testbench;
  import lsi_pkg::*;

  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    logic            hit;
    logic            unbounded;
    logic [T_W-1:0]  t_near;
    logic [T_W-1:0]  t_far;
  } isect_t;

  // One directed request: source point, direction and, where it is obvious,
  // the result typed in by hand.
  typedef struct packed {
    logic signed [CRD_W-1:0] sx, sy, sz, dx, dy, dz;
    logic                    known;
    isect_t                  result;
  } ray_row_t;

  localparam logic signed [CRD_W-1:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [CRD_W-1:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [CRD_W-1:0] ONE   = 32'sh0001_0000;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 200;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  lsi_ray_if ray_ch ();
  lsi_res_if res_ch ();

  line_sphere_intersect_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .ray      (ray_ch),
    .res      (res_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // Shadow copy of the sphere registers, updated as each write lands.
  logic signed [CRD_W-1:0] sph_cx, sph_cy, sph_cz;
  logic [RAD_W-1:0] sph_r;

  isect_t pending_isect[$];   // predicted results in request order
  int errors;
  int idle_cycles;
  bit calm;                   // when set, neither side idles

  // Hand-typed expectation travels with the request it belongs to.
  logic known_now;
  isect_t known_isect;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Floor division toward minus infinity; divisor is always positive.
  function automatic wide_t floor_div(input wide_t n, input wide_t d);
    wide_t q;
    q = n / d;
    if (n < 0 && (n % d) != 0) q = q - 1;
    return q;
  endfunction

  function automatic logic [T_W-1:0] clamp_t(input wide_t v);
    if (v > wide_t'(T_MAX)) return T_MAX;
    if (v < wide_t'($signed(T_MIN))) return T_MIN;
    return v[T_W-1:0];
  endfunction

  // Exact solve of (D.D)t^2 - 2(O.D)t + (O.O - r^2) = 0, with O = C - S.
  function automatic isect_t solve_isect(input logic signed [CRD_W-1:0] sx, sy, sz,
                                         dx, dy, dz);
    wide_t ox, oy, oz, wx, wy, wz, a, b, c, disc, x, y, s, sc, t;
    isect_t r;
    r = '0;
    ox = wide_t'(sph_cx) - wide_t'(sx);
    oy = wide_t'(sph_cy) - wide_t'(sy);
    oz = wide_t'(sph_cz) - wide_t'(sz);
    wx = wide_t'(dx);
    wy = wide_t'(dy);
    wz = wide_t'(dz);
    a = wx * wx + wy * wy + wz * wz;
    b = ox * wx + oy * wy + oz * wz;
    c = ox * ox + oy * oy + oz * oz - wide_t'(sph_r) * wide_t'(sph_r);
    if (a == 0) begin
      // degenerate line: only a point, inside means every t works
      if (c < 0) begin
        r.hit = 1'b1;
        r.unbounded = 1'b1;
        r.t_near = T_MIN;
        r.t_far = T_MAX;
      end
      return r;
    end
    disc = b * b - a * c;
    if (disc < 0) return r;
    x = b <<< FRAC_BITS;
    y = disc <<< (2 * FRAC_BITS);
    s = 0;
    for (int i = 95; i >= 0; i--) begin
      t = s | (wide_t'(1) << i);
      if (t * t <= y) s = t;
    end
    // round the root up for the near side so both ends floor correctly
    sc = (s * s != y) ? s + 1 : s;
    r.hit = 1'b1;
    r.t_near = clamp_t(floor_div(x - sc, a));
    r.t_far = clamp_t(floor_div(x + s, a));
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [T_W-1:0] got,
                                 input logic [T_W-1:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    errors++;
  endtask

  // Scoreboard: predict on every accepted request, check on every result.
  always @(posedge clk) begin
    isect_t want;
    if (!rst) begin
      if (ray_ch.valid && ray_ch.ready) begin
        if (known_now) pending_isect.push_back(known_isect);
        else pending_isect.push_back(solve_isect(ray_ch.source_x, ray_ch.source_y,
                                                 ray_ch.source_z, ray_ch.dir_x,
                                                 ray_ch.dir_y, ray_ch.dir_z));
      end
      if (res_ch.valid && res_ch.ready) begin
        if (pending_isect.size() == 0) begin
          $display("%0t: result with no request outstanding", $realtime);
          errors++;
        end else begin
          want = pending_isect.pop_front();
          if (res_ch.hit !== want.hit)
            report_mismatch("hit", T_W'(res_ch.hit), T_W'(want.hit));
          if (res_ch.unbounded !== want.unbounded)
            report_mismatch("unbounded", T_W'(res_ch.unbounded), T_W'(want.unbounded));
          if (res_ch.t_near !== want.t_near)
            report_mismatch("t_near", res_ch.t_near, want.t_near);
          if (res_ch.t_far !== want.t_far)
            report_mismatch("t_far", res_ch.t_far, want.t_far);
        end
      end
    end
  end

  // Watchdog on progress: any handshake on either side resets it.
  always @(posedge clk) begin
    if (rst || (ray_ch.valid && ray_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Result side back-pressure: random stall before each result.
  initial begin
    int stall;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
    end
  end

  // Present one request after a random gap and hold it until taken.
  task automatic send_ray(input ray_row_t row);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      ray_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ray_ch.valid <= 1'b1;
    ray_ch.source_x <= row.sx;
    ray_ch.source_y <= row.sy;
    ray_ch.source_z <= row.sz;
    ray_ch.dir_x <= row.dx;
    ray_ch.dir_y <= row.dy;
    ray_ch.dir_z <= row.dz;
    known_now <= row.known;
    known_isect <= row.result;
    do @(posedge clk); while (!ray_ch.ready);
  endtask

  // Let every outstanding result come back before touching the registers.
  task automatic drain();
    ray_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_isect.size() != 0) @(posedge clk);
  endtask

  task automatic load_sphere(input logic signed [CRD_W-1:0] cx, cy, cz,
                             input logic [RAD_W-1:0] rad);
    cfg_we <= 1'b1;
    cfg_idx <= REG_CENTER_X; cfg_data <= cx; @(posedge clk); sph_cx = cx;
    cfg_idx <= REG_CENTER_Y; cfg_data <= cy; @(posedge clk); sph_cy = cy;
    cfg_idx <= REG_CENTER_Z; cfg_data <= cz; @(posedge clk); sph_cz = cz;
    cfg_idx <= REG_RADIUS; cfg_data <= {1'b0, rad}; @(posedge clk); sph_r = rad;
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [CRD_W-1:0] near_val(input logic signed [CRD_W-1:0] base,
                                                       input int span);
    return base + $signed(CRD_W'($urandom_range(0, 2 * span))) - span;
  endfunction

  // Random request: mostly lines aimed near the sphere, some raw noise.
  function automatic ray_row_t random_ray();
    ray_row_t row;
    int span, dspan;
    row = '0;
    span = (sph_r > 0 && sph_r < 31'h0100_0000) ? 3 * int'(sph_r) : 32'h0040_0000;
    dspan = 1 << $urandom_range(0, 20);
    case ($urandom_range(0, 7))
      0, 1: begin
        row.sx = $urandom; row.sy = $urandom; row.sz = $urandom;
        row.dx = $urandom; row.dy = $urandom; row.dz = $urandom;
      end
      2: begin
        // degenerate line near the surface
        row.sx = near_val(sph_cx, span);
        row.sy = near_val(sph_cy, span);
        row.sz = near_val(sph_cz, span);
      end
      3: begin
        row.sx = near_val(sph_cx, span);
        row.sy = near_val(sph_cy, span);
        row.sz = near_val(sph_cz, span);
        row.dx = $urandom; row.dy = $urandom; row.dz = $urandom;
      end
      default: begin
        row.sx = near_val(sph_cx, span);
        row.sy = near_val(sph_cy, span);
        row.sz = near_val(sph_cz, span);
        row.dx = near_val(0, dspan);
        row.dy = near_val(0, dspan);
        row.dz = near_val(0, dspan);
      end
    endcase
    return row;
  endfunction

  function automatic ray_row_t mk_row(input logic signed [CRD_W-1:0] sx, sy, sz,
                                      dx, dy, dz, input int known,
                                      input int hit, input int unb,
                                      input logic [T_W-1:0] tn, input logic [T_W-1:0] tf);
    ray_row_t row;
    row.sx = sx; row.sy = sy; row.sz = sz;
    row.dx = dx; row.dy = dy; row.dz = dz;
    row.known = known[0];
    row.result = '{hit[0], unb[0], tn, tf};
    return row;
  endfunction

  ray_row_t directed_rows[$];

  initial begin
    errors = 0;
    calm = 1'b0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_idx <= REG_CENTER_X;
    cfg_data <= '0;
    known_now <= 1'b0;
    known_isect <= '0;
    ray_ch.valid <= 1'b0;
    ray_ch.source_x <= '0; ray_ch.source_y <= '0; ray_ch.source_z <= '0;
    ray_ch.dir_x <= '0; ray_ch.dir_y <= '0; ray_ch.dir_z <= '0;
    sph_cx = '0; sph_cy = '0; sph_cz = '0;
    sph_r = RADIUS_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part against the reset sphere: unit radius at the origin.
    // zero direction: inside gives an unbounded hit, on or outside a miss
    directed_rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 1, 1, 1, T_MIN, T_MAX));
    directed_rows.push_back(mk_row(-1, -1, -1, 0, 0, 0, 1, 1, 1, T_MIN, T_MAX));
    directed_rows.push_back(mk_row(2 * ONE, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(ONE, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
    // plain secant along x: enters at t = 1, leaves at t = 3
    directed_rows.push_back(mk_row(-2 * ONE, 0, 0, ONE, 0, 0, 1, 1, 0, ONE, 3 * ONE));
    // tangent line touches at t = 2
    directed_rows.push_back(mk_row(-2 * ONE, ONE, 0, ONE, 0, 0, 1, 1, 0, 2 * ONE, 2 * ONE));
    // clear miss
    directed_rows.push_back(mk_row(-2 * ONE, 2 * ONE, 0, ONE, 0, 0, 1, 0, 0, 0, 0));
    // extremes, roots out of range saturate
    directed_rows.push_back(mk_row(S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, S_MAX, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(-S_MAX, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(-S_MAX, 0, 0, -1, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(S_MAX, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(0, 0, 0, 1, 1, 1, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(-1, -1, -1, -1, -1, -1, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(0, S_MIN, 0, 0, S_MAX, 0, 0, 0, 0, 0, 0));
    foreach (directed_rows[i]) send_ray(directed_rows[i]);
    ray_ch.valid <= 1'b0;
    known_now <= 1'b0;
    @(posedge clk);
    drain();

    // Random part over several spheres, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_sphere(0, 0, 0, RADIUS_RESET);
        1: load_sphere(S_MIN, S_MIN, S_MIN, 31'h7FFF_FFFF);
        2: load_sphere(S_MAX, S_MAX, S_MAX, 31'h0);
        3: load_sphere(S_MAX, S_MIN, 0, 31'h7FFF_FFFF);
        4: load_sphere($urandom, $urandom, $urandom,
                       RAD_W'($urandom_range(1, 32'h0100_0000)));
        default: load_sphere($urandom, $urandom, $urandom, RAD_W'($urandom));
      endcase
      for (int n = 0; n < 150; n++) begin
        if (n % 50 == 0) calm = ($urandom_range(0, 3) == 0);
        send_ray(random_ray());
      end
      calm = 1'b0;
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending_isect.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
